// ===== rtl/fsfl_pkg.sv =====
package fsfl_pkg;

  localparam int unsigned MAX_SLOTS  = 1024;
  localparam int unsigned WORD_BYTES = 8;

  localparam int unsigned SLOT_W  = $clog2(MAX_SLOTS);
  localparam int unsigned LINK_W  = SLOT_W + 1;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned SB_W    = SIZE_W + 1;
  localparam int unsigned BYTES_W = 27;
  localparam int unsigned SCNT_W  = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_SLOTS);

  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd1;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RESIZE  = 2'd2,
    ACT_REBUILD = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  granted;
    logic [COUNT_W-1:0] used;
  } res_t;

endpackage

// ===== rtl/fsfl_link_mem.sv =====
module fsfl_link_mem (
  input  logic                             clk_i,
  input  fsfl_pkg::mem_req_t               req_i,
  output logic [fsfl_pkg::LINK_W-1:0]      rdata_o
);

  logic [fsfl_pkg::LINK_W-1:0] mem [fsfl_pkg::MAX_SLOTS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

// ===== rtl/fsfl_ctrl.sv =====
module fsfl_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic                              slot_valid_i,
  input  logic [fsfl_pkg::SLOT_W-1:0]       slot_index_i,
  input  logic [fsfl_pkg::SIZE_W-1:0]       request_size_i,
  input  logic [fsfl_pkg::SB_W-1:0]         slot_bytes_i,
  input  logic [fsfl_pkg::SCNT_W-1:0]       slot_count_i,
  output fsfl_pkg::mem_req_t                mem_req_o,
  input  logic [fsfl_pkg::LINK_W-1:0]       mem_rdata_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output fsfl_pkg::res_t                    res_o
);

  fsfl_pkg::state_e state_q, state_d;
  logic [fsfl_pkg::LINK_W-1:0]  head_q, head_d;
  logic [fsfl_pkg::COUNT_W-1:0] used_q, used_d;
  logic [fsfl_pkg::SLOT_W-1:0]  walk_q, walk_d;
  logic                         ok_q, ok_d;
  logic [fsfl_pkg::SLOT_W-1:0]  granted_q, granted_d;

  fsfl_pkg::action_e            act;
  logic                         accept;
  logic                         is_alloc;
  logic                         fits;
  logic [fsfl_pkg::LINK_W-1:0]  link_cnt;
  logic [fsfl_pkg::LINK_W-1:0]  walk_next;
  logic                         walk_last;

  assign act      = fsfl_pkg::action_e'(action_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign is_alloc = (act == fsfl_pkg::ACT_ALLOC) ||
                    ((act == fsfl_pkg::ACT_RESIZE) && !slot_valid_i);
  assign fits     = {1'b0, request_size_i} <= slot_bytes_i;

  // rebuild length, clamped to the pool size
  assign link_cnt  = (slot_count_i > fsfl_pkg::SCNT_W'(fsfl_pkg::MAX_SLOTS)) ?
                     fsfl_pkg::LINK_NULL : fsfl_pkg::LINK_W'(slot_count_i);
  assign walk_next = {1'b0, walk_q} + fsfl_pkg::LINK_W'(1);
  assign walk_last = walk_next == link_cnt;

  assign in_stall_o  = state_q != fsfl_pkg::ST_IDLE;
  assign res_valid_o = state_q == fsfl_pkg::ST_DONE;
  assign res_o.ok      = ok_q;
  assign res_o.granted = granted_q;
  assign res_o.used    = used_q;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    used_d    = used_q;
    walk_d    = walk_q;
    ok_d      = ok_q;
    granted_d = granted_q;
    mem_req_o = '0;

    case (state_q)
      fsfl_pkg::ST_IDLE: begin
        if (accept) begin
          ok_d      = 1'b1;
          granted_d = '0;
          state_d   = fsfl_pkg::ST_DONE;
          if (is_alloc) begin
            if (!fits || head_q[fsfl_pkg::LINK_W-1]) begin
              ok_d = 1'b0;
            end else begin
              // pop: fetch the head's link, commit next cycle
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = head_q[fsfl_pkg::SLOT_W-1:0];
              granted_d       = head_q[fsfl_pkg::SLOT_W-1:0];
              state_d         = fsfl_pkg::ST_READ;
            end
          end else begin
            case (act)
              fsfl_pkg::ACT_FREE: begin
                if (slot_valid_i) begin
                  mem_req_o.we    = 1'b1;
                  mem_req_o.waddr = slot_index_i;
                  mem_req_o.wdata = head_q;
                  head_d          = {1'b0, slot_index_i};
                  used_d          = used_q - fsfl_pkg::COUNT_W'(1);
                end
              end
              fsfl_pkg::ACT_RESIZE: begin
                if (fits) begin
                  granted_d = slot_index_i;
                end else begin
                  ok_d = 1'b0;
                end
              end
              fsfl_pkg::ACT_REBUILD: begin
                used_d = '0;
                walk_d = '0;
                if (link_cnt == '0) begin
                  head_d = fsfl_pkg::LINK_NULL;
                end else begin
                  head_d  = '0;
                  state_d = fsfl_pkg::ST_WALK;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      fsfl_pkg::ST_READ: begin
        head_d  = mem_rdata_i;
        used_d  = used_q + fsfl_pkg::COUNT_W'(1);
        state_d = fsfl_pkg::ST_DONE;
      end
      fsfl_pkg::ST_WALK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = walk_q;
        mem_req_o.wdata = walk_last ? fsfl_pkg::LINK_NULL : walk_next;
        walk_d          = walk_next[fsfl_pkg::SLOT_W-1:0];
        if (walk_last) begin
          state_d = fsfl_pkg::ST_DONE;
        end
      end
      fsfl_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = fsfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fsfl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsfl_pkg::ST_IDLE;
      head_q  <= fsfl_pkg::LINK_NULL;
      used_q  <= '0;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      used_q  <= used_d;
      walk_q  <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q      <= ok_d;
    granted_q <= granted_d;
  end

endmodule

// ===== rtl/fsfl_out_stage.sv =====
module fsfl_out_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              res_valid_i,
  output logic                              res_ready_o,
  input  fsfl_pkg::res_t                    res_i,
  input  logic [fsfl_pkg::SB_W-1:0]         slot_bytes_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic [fsfl_pkg::SLOT_W-1:0]       granted_slot_o,
  output logic [fsfl_pkg::COUNT_W-1:0]      used_slots_o,
  output logic [fsfl_pkg::BYTES_W-1:0]      used_bytes_o
);

  logic                                         out_valid_q, out_valid_d;
  logic                                         load;
  logic [fsfl_pkg::COUNT_W+fsfl_pkg::SB_W-1:0]  prod;

  assign res_ready_o = !out_valid_q || !out_stall_i;
  assign load        = res_valid_i && res_ready_o;
  assign prod        = (fsfl_pkg::COUNT_W + fsfl_pkg::SB_W)'(res_i.used) *
                       (fsfl_pkg::COUNT_W + fsfl_pkg::SB_W)'(slot_bytes_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ok_o           <= res_i.ok;
      granted_slot_o <= res_i.granted;
      used_slots_o   <= res_i.used;
      used_bytes_o   <= prod[fsfl_pkg::BYTES_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/fixed_slot_free_list_allocator.sv =====
// an input transfer passes through the controller's result register into the output register;
// an allocate that pops a slot first does one link-memory read, and a rebuild of n slots
// (n is slot_count clamped to the pool) writes one link per cycle, none when n is zero;
// a new item is taken once the previous result has moved into the output register
// reset: free list empty, used count zero, object size 8, slot count 1024, links undefined
module fixed_slot_free_list_allocator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [fsfl_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [fsfl_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            action_i,
  input  logic                                  slot_valid_i,
  input  logic [fsfl_pkg::SLOT_W-1:0]           slot_index_i,
  input  logic [fsfl_pkg::SIZE_W-1:0]           request_size_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  ok_o,
  output logic [fsfl_pkg::SLOT_W-1:0]           granted_slot_o,
  output logic [fsfl_pkg::COUNT_W-1:0]          used_slots_o,
  output logic [fsfl_pkg::BYTES_W-1:0]          used_bytes_o
);

  logic [fsfl_pkg::SB_W-1:0]    slot_bytes_q, slot_bytes_d;
  logic [fsfl_pkg::SCNT_W-1:0]  slot_count_q, slot_count_d;
  logic [fsfl_pkg::SIZE_W-1:0]  obj_min;
  logic [fsfl_pkg::SB_W-1:0]    obj_sum;

  fsfl_pkg::mem_req_t           mem_req;
  logic [fsfl_pkg::LINK_W-1:0]  mem_rdata;
  logic                         res_valid;
  logic                         res_ready;
  fsfl_pkg::res_t               res;

  // slot size: at least one word, rounded up to whole words
  assign obj_min = (cfg_data_i < fsfl_pkg::SIZE_W'(fsfl_pkg::WORD_BYTES)) ?
                   fsfl_pkg::SIZE_W'(fsfl_pkg::WORD_BYTES) : cfg_data_i;
  assign obj_sum = {1'b0, obj_min} + fsfl_pkg::SB_W'(fsfl_pkg::WORD_BYTES - 1);

  always_comb begin
    slot_bytes_d = slot_bytes_q;
    slot_count_d = slot_count_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fsfl_pkg::CFG_OBJECT_SIZE: begin
          slot_bytes_d = obj_sum & ~fsfl_pkg::SB_W'(fsfl_pkg::WORD_BYTES - 1);
        end
        fsfl_pkg::CFG_SLOT_COUNT: begin
          slot_count_d = cfg_data_i[fsfl_pkg::SCNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_bytes_q <= fsfl_pkg::SB_W'(fsfl_pkg::WORD_BYTES);
      slot_count_q <= fsfl_pkg::SCNT_W'(fsfl_pkg::MAX_SLOTS);
    end else begin
      slot_bytes_q <= slot_bytes_d;
      slot_count_q <= slot_count_d;
    end
  end

  fsfl_link_mem u_link_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  fsfl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .slot_valid_i   (slot_valid_i),
    .slot_index_i   (slot_index_i),
    .request_size_i (request_size_i),
    .slot_bytes_i   (slot_bytes_q),
    .slot_count_i   (slot_count_q),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  fsfl_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_valid_i    (res_valid),
    .res_ready_o    (res_ready),
    .res_i          (res),
    .slot_bytes_i   (slot_bytes_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .granted_slot_o (granted_slot_o),
    .used_slots_o   (used_slots_o),
    .used_bytes_o   (used_bytes_o)
  );

endmodule

// ===== bench/fixed_slot_free_list_allocator_tb.sv =====
`timescale 1ns / 100ps

module fixed_slot_free_list_allocator_tb;
  import fsfl_pkg::*;

  typedef struct packed {
    action_e            action;
    logic               slot_valid;
    logic [SLOT_W-1:0]  slot_index;
    logic [SIZE_W-1:0]  request_size;
  } pool_op_t;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  granted_slot;
    logic [COUNT_W-1:0] used_slots;
    logic [BYTES_W-1:0] used_bytes;
    logic               pops;
  } pool_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            action_i = '0;
  logic                  slot_valid_i = 1'b0;
  logic [SLOT_W-1:0]     slot_index_i = '0;
  logic [SIZE_W-1:0]     request_size_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  ok_o;
  logic [SLOT_W-1:0]     granted_slot_o;
  logic [COUNT_W-1:0]    used_slots_o;
  logic [BYTES_W-1:0]    used_bytes_o;

  fixed_slot_free_list_allocator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .slot_valid_i   (slot_valid_i),
    .slot_index_i   (slot_index_i),
    .request_size_i (request_size_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .granted_slot_o (granted_slot_o),
    .used_slots_o   (used_slots_o),
    .used_bytes_o   (used_bytes_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the pool
  logic [LINK_W-1:0]  shadow_link [MAX_SLOTS];
  logic [LINK_W-1:0]  shadow_head = LINK_NULL;
  logic [COUNT_W-1:0] shadow_used = '0;
  logic [SIZE_W-1:0]  shadow_obj_size = SIZE_W'(8);
  logic [SCNT_W-1:0]  shadow_slot_count = SCNT_W'(1024);

  pool_op_t          pending_ops [$];
  pool_result_t      expected_results [$];
  logic [SLOT_W-1:0] live_slots [$];
  pool_op_t          cur_op;
  bit                offering = 1'b0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       hold_left = 0;
  int unsigned       mismatches = 0;

  function automatic logic [SB_W-1:0] slot_size_of(logic [SIZE_W-1:0] obj);
    logic [SB_W-1:0] s;
    s = (obj < WORD_BYTES) ? SB_W'(WORD_BYTES) : SB_W'(obj);
    return SB_W'(((s + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES);
  endfunction

  function automatic pool_result_t pool_step(pool_op_t op);
    pool_result_t    r;
    logic [SB_W-1:0] sb;
    int unsigned     n;
    logic [63:0]     prod;
    sb = slot_size_of(shadow_obj_size);
    r = '0;
    r.ok = 1'b1;
    if (op.action == ACT_ALLOC || (op.action == ACT_RESIZE && !op.slot_valid)) begin
      r.pops = 1'b1;
      if (SB_W'(op.request_size) <= sb && shadow_head < LINK_NULL) begin
        r.granted_slot = shadow_head[SLOT_W-1:0];
        shadow_head = shadow_link[shadow_head[SLOT_W-1:0]];
        shadow_used = shadow_used + 1'b1;
      end else begin
        r.ok = 1'b0;
      end
    end else if (op.action == ACT_FREE) begin
      // a 10-bit index always names a slot, double frees are pushed again
      if (op.slot_valid) begin
        shadow_link[op.slot_index] = shadow_head;
        shadow_head = LINK_W'(op.slot_index);
        shadow_used = shadow_used - 1'b1;
      end
    end else if (op.action == ACT_RESIZE) begin
      if (SB_W'(op.request_size) <= sb) r.granted_slot = op.slot_index;
      else r.ok = 1'b0;
    end else begin
      n = (shadow_slot_count > MAX_SLOTS) ? MAX_SLOTS : shadow_slot_count;
      for (int i = 0; i < n; i++)
        shadow_link[i] = (i + 1 < n) ? LINK_W'(i + 1) : LINK_NULL;
      shadow_head = (n > 0) ? '0 : LINK_NULL;
      shadow_used = '0;
    end
    prod = 64'(shadow_used) * 64'(sb);
    r.used_slots = shadow_used;
    r.used_bytes = prod[BYTES_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver: holds the offered op until its transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (offering && !in_stall_o) begin
        expected_results.push_back(pool_step(cur_op));
        offering = 1'b0;
      end
      if (!offering && pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_op = pending_ops.pop_front();
        offering = 1'b1;
        action_i       <= cur_op.action;
        slot_valid_i   <= cur_op.slot_valid;
        slot_index_i   <= cur_op.slot_index;
        request_size_i <= cur_op.request_size;
      end
      in_valid_i <= offering;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pool_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (ok_o !== want.ok) flag_mismatch("ok", ok_o, want.ok);
          if (granted_slot_o !== want.granted_slot)
            flag_mismatch("granted_slot", granted_slot_o, want.granted_slot);
          if (used_slots_o !== want.used_slots)
            flag_mismatch("used_slots", used_slots_o, want.used_slots);
          if (used_bytes_o !== want.used_bytes)
            flag_mismatch("used_bytes", used_bytes_o, want.used_bytes);
          if (want.ok && want.pops) live_slots.push_back(want.granted_slot);
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic push_op(input action_e act, input bit v, input int unsigned idx,
                         input int unsigned size);
    pool_op_t op;
    op.action       = act;
    op.slot_valid   = v;
    op.slot_index   = SLOT_W'(idx);
    op.request_size = SIZE_W'(size);
    pending_ops.push_back(op);
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || offering || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_OBJECT_SIZE) shadow_obj_size = SIZE_W'(val);
    else if (idx == CFG_SLOT_COUNT) shadow_slot_count = SCNT_W'(val);
  endtask

  task automatic set_pool(input int unsigned obj, input int unsigned cnt);
    drain();
    write_reg(CFG_OBJECT_SIZE, obj);
    write_reg(CFG_SLOT_COUNT, cnt);
  endtask

  // wait for quiet so no grant from before the relink lands in the live list
  task automatic rebuild_fresh();
    drain();
    live_slots.delete();
    push_op(ACT_REBUILD, 1'b0, 0, 0);
  endtask

  function automatic int unsigned pick_size(logic [SB_W-1:0] sb);
    int unsigned top;
    top = (sb > 65535) ? 65535 : sb;
    case ($urandom_range(9))
      0: return $urandom_range(65535);
      1: return top;
      2: return (top == 65535) ? top : top + 1;
      default: return $urandom_range(top);
    endcase
  endfunction

  task automatic run_random_phase(input int unsigned n);
    logic [SB_W-1:0] sb;
    int unsigned     r;
    int unsigned     j;
    action_e         act;
    sb = slot_size_of(shadow_obj_size);
    rebuild_fresh();
    for (int k = 1; k < n; k++) begin
      while (pending_ops.size() >= 2) @(posedge clk_i);
      r = $urandom_range(99);
      if (r >= 40 && r < 80 && live_slots.size() == 0) r = 0;
      if (r < 40) begin
        push_op(ACT_ALLOC, $urandom_range(1), $urandom_range(1023), pick_size(sb));
      end else if (r < 70) begin
        j = $urandom_range(live_slots.size() - 1);
        push_op(ACT_FREE, 1'b1, live_slots[j], $urandom_range(65535));
        live_slots.delete(j);
      end else if (r < 80) begin
        j = $urandom_range(live_slots.size() - 1);
        push_op(ACT_RESIZE, 1'b1, live_slots[j], pick_size(sb));
      end else if (r < 85) begin
        // stray or double free
        push_op(ACT_FREE, $urandom_range(1), $urandom_range(1023), $urandom_range(65535));
      end else if (r < 90) begin
        push_op(ACT_RESIZE, 1'b0, $urandom_range(1023), pick_size(sb));
      end else if (r < 94) begin
        rebuild_fresh();
      end else begin
        act = action_e'(2'($urandom_range(3)));
        if (act == ACT_REBUILD) rebuild_fresh();
        else push_op(act, $urandom_range(1), $urandom_range(1023), $urandom_range(65535));
      end
    end
  endtask

  initial begin
    int unsigned obj;
    int unsigned cnt;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, list empty until the first relink
    push_op(ACT_ALLOC, 1'b0, 0, 8);
    push_op(ACT_FREE, 1'b0, 0, 0);
    push_op(ACT_RESIZE, 1'b0, 0, 0);
    push_op(ACT_REBUILD, 1'b0, 0, 0);
    push_op(ACT_ALLOC, 1'b0, 0, 8);
    push_op(ACT_ALLOC, 1'b0, 0, 9);
    push_op(ACT_ALLOC, 1'b1, 1023, 0);
    push_op(ACT_RESIZE, 1'b1, 0, 8);
    push_op(ACT_RESIZE, 1'b1, 0, 9);
    push_op(ACT_RESIZE, 1'b0, 0, 3);
    push_op(ACT_FREE, 1'b1, 1, 0);
    push_op(ACT_FREE, 1'b1, 1023, 0);
    push_op(ACT_ALLOC, 1'b0, 0, 1);

    // largest slot, two slots, count wraps below zero
    set_pool(65535, 2);
    push_op(ACT_REBUILD, 1'b0, 0, 0);
    push_op(ACT_ALLOC, 1'b0, 0, 65535);
    push_op(ACT_ALLOC, 1'b0, 0, 65535);
    push_op(ACT_ALLOC, 1'b0, 0, 0);
    push_op(ACT_FREE, 1'b1, 1, 65535);
    push_op(ACT_FREE, 1'b1, 1, 0);
    push_op(ACT_FREE, 1'b1, 1, 0);
    push_op(ACT_RESIZE, 1'b1, 1023, 65535);

    // zero object size and zero slot count
    set_pool(0, 0);
    push_op(ACT_REBUILD, 1'b0, 0, 0);
    push_op(ACT_ALLOC, 1'b0, 0, 0);
    push_op(ACT_FREE, 1'b1, 5, 0);
    push_op(ACT_ALLOC, 1'b0, 0, 8);

    // slot count beyond the pool is clamped
    set_pool(1, 2047);
    push_op(ACT_REBUILD, 1'b0, 0, 0);
    push_op(ACT_ALLOC, 1'b0, 0, 8);

    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(6))
        0: obj = 1;
        1: obj = 8;
        2: obj = 9;
        3: obj = 65528;
        4: obj = 65535;
        5: obj = 0;
        default: obj = $urandom_range(512, 1);
      endcase
      cnt = $urandom_range(48, 1);
      if (p == 1) begin
        obj = 65528;
        cnt = 1;
      end
      if (p == 3) cnt = 1024;
      if (p == 7) cnt = 2047;
      if (p == 9) cnt = 0;
      set_pool(obj, cnt);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (p == 5) begin
        // sender keeps offering while the output is held back
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 300;
      end
      run_random_phase(46);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("fixed_slot_free_list_allocator_tb passed");
    else $display("fixed_slot_free_list_allocator_tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("fixed_slot_free_list_allocator_tb failed");
    $finish;
  end

endmodule
